// File: hdl/dtnp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Decimal text parser package
// Holds the transaction types and the character and limit constants that the
// parser uses.
// ----------------------------------------------------------------------------
package dtnp_pkg;

  localparam int unsigned MANT_W      = 60;
  localparam int unsigned EXP_OUT_W   = 16;
  localparam int unsigned SCALE_LIMIT = 20000;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LO_E  = 8'h65;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_last;
  } in_t;

  typedef struct packed {
    logic                        negative;
    logic [MANT_W-1:0]           mantissa;
    logic signed [EXP_OUT_W-1:0] dec_exponent;
    logic                        inexact;
    logic                        exp_saturated;
  } out_t;

endpackage
`default_nettype wire

// File: hdl/decimal_text_to_number_parser_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Decimal text to number parser core
// Parses one character per transaction and emits sign, decimal mantissa and
// decimal exponent after the character marked last.
// A result passes the input register, then the result register. Throughput: one
// character per cycle, but a last character waits while a result is unread; the
// state logic is combinational from input register to state and result registers.
// Reset clears the parser state and both valid flags; no clearing pass.
// ----------------------------------------------------------------------------
module decimal_text_to_number_parser_core #(
  parameter int unsigned MANT_DIGITS = 18,
  parameter int unsigned EXP_LIMIT   = 9999
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  dtnp_pkg::in_t     in_data_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output dtnp_pkg::out_t    out_data_o
);
  import dtnp_pkg::*;

  localparam int unsigned CNT_W = $clog2(MANT_DIGITS + 1);
  localparam int unsigned EXP_W = $clog2(EXP_LIMIT + 1);
  localparam int unsigned EXT_W = EXP_W + 4;
  localparam int unsigned SUM_W = EXP_OUT_W + 1;

  localparam logic signed [EXP_OUT_W-1:0] SCALE_HI = EXP_OUT_W'(SCALE_LIMIT);
  localparam logic signed [EXP_OUT_W-1:0] SCALE_LO = -EXP_OUT_W'(SCALE_LIMIT);
  localparam logic signed [SUM_W-1:0]     SUM_HI   = SUM_W'(SCALE_LIMIT);
  localparam logic signed [SUM_W-1:0]     SUM_LO   = -SUM_W'(SCALE_LIMIT);

  typedef enum logic [3:0] {
    PH_SPACE, PH_SIGN, PH_INT, PH_DOT, PH_FRAC, PH_E, PH_ESIGN, PH_EXP, PH_DONE
  } phase_e;

  typedef enum logic [2:0] {
    ACT_NONE, ACT_SIGN, ACT_INT, ACT_FRAC, ACT_ESIGN, ACT_EXP
  } act_e;

  in_t                          in_q;
  logic                         in_valid_q;
  logic                         fire;

  phase_e                       phase_q, phase_d;
  logic                         neg_q, neg_d;
  logic [MANT_W-1:0]            mant_q, mant_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic signed [EXP_OUT_W-1:0]  scale_q, scale_d;
  logic [EXP_W-1:0]             exp_q, exp_d;
  logic                         exp_neg_q, exp_neg_d;
  logic                         lost_q, lost_d;
  logic                         exp_ovf_q, exp_ovf_d;

  logic                         out_valid_q;
  out_t                         out_q;
  out_t                         result;

  logic                         is_space, is_sign, is_digit, is_e;
  logic                         taken;
  act_e                         act;
  logic [3:0]                   digit;
  logic [EXT_W-1:0]             exp_ext;
  logic signed [SUM_W-1:0]      exp_sum;

  assign fire       = in_valid_q && (!in_q.is_last || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;

  assign is_space = (in_q.ch == CH_SPACE) || ((in_q.ch >= CH_TAB) && (in_q.ch <= CH_CR));
  assign is_sign  = (in_q.ch == CH_PLUS) || (in_q.ch == CH_MINUS);
  assign is_digit = (in_q.ch >= CH_ZERO) && (in_q.ch <= CH_NINE);
  assign is_e     = (in_q.ch == CH_LO_E) || (in_q.ch == CH_UP_E);
  assign digit    = 4'(in_q.ch - CH_ZERO);

  always_comb begin
    phase_d = phase_q;
    taken   = 1'b0;
    act     = ACT_NONE;
    if (phase_d == PH_SPACE) begin
      if (is_space) taken = 1'b1;
      else phase_d = PH_SIGN;
    end
    if (!taken && phase_d == PH_SIGN) begin
      phase_d = PH_INT;
      if (is_sign) begin
        taken = 1'b1;
        act   = ACT_SIGN;
      end
    end
    if (!taken && phase_d == PH_INT) begin
      if (is_digit) begin
        taken = 1'b1;
        act   = ACT_INT;
      end else begin
        phase_d = PH_DOT;
      end
    end
    if (!taken && phase_d == PH_DOT) begin
      phase_d = PH_FRAC;
      if (in_q.ch == CH_DOT) taken = 1'b1;
    end
    if (!taken && phase_d == PH_FRAC) begin
      if (is_digit) begin
        taken = 1'b1;
        act   = ACT_FRAC;
      end else begin
        phase_d = PH_E;
      end
    end
    if (!taken && phase_d == PH_E) begin
      phase_d = PH_ESIGN;
      if (is_e) taken = 1'b1;
    end
    if (!taken && phase_d == PH_ESIGN) begin
      phase_d = PH_EXP;
      if (is_sign) begin
        taken = 1'b1;
        act   = ACT_ESIGN;
      end
    end
    if (!taken && phase_d == PH_EXP) begin
      if (is_digit) begin
        taken = 1'b1;
        act   = ACT_EXP;
      end else begin
        phase_d = PH_DONE;
      end
    end
  end

  always_comb begin
    neg_d     = neg_q;
    mant_d    = mant_q;
    cnt_d     = cnt_q;
    scale_d   = scale_q;
    exp_d     = exp_q;
    exp_neg_d = exp_neg_q;
    lost_d    = lost_q;
    exp_ovf_d = exp_ovf_q;
    exp_ext   = (EXT_W'(exp_q) << 3) + (EXT_W'(exp_q) << 1) + EXT_W'(digit);
    case (act)
      ACT_SIGN: neg_d = (in_q.ch == CH_MINUS);
      ACT_ESIGN: exp_neg_d = (in_q.ch == CH_MINUS);
      ACT_INT, ACT_FRAC: begin
        if (cnt_q == '0 && digit == 4'd0) begin
          if (act == ACT_FRAC && scale_q != SCALE_LO) scale_d = scale_q - EXP_OUT_W'(1);
        end else if (cnt_q < CNT_W'(MANT_DIGITS)) begin
          mant_d = (mant_q << 3) + (mant_q << 1) + MANT_W'(digit);
          cnt_d  = cnt_q + 1'b1;
          if (act == ACT_FRAC && scale_q != SCALE_LO) scale_d = scale_q - EXP_OUT_W'(1);
        end else begin
          lost_d = 1'b1;
          if (act == ACT_INT && scale_q != SCALE_HI) scale_d = scale_q + EXP_OUT_W'(1);
        end
      end
      ACT_EXP: begin
        if (exp_ext > EXT_W'(EXP_LIMIT)) begin
          exp_d     = EXP_W'(EXP_LIMIT);
          exp_ovf_d = 1'b1;
        end else begin
          exp_d = exp_ext[EXP_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (exp_neg_d) exp_sum = SUM_W'(scale_d) - $signed(SUM_W'(exp_d));
    else exp_sum = SUM_W'(scale_d) + $signed(SUM_W'(exp_d));
    result.negative      = neg_d;
    result.mantissa      = mant_d;
    result.inexact       = lost_d;
    result.exp_saturated = exp_ovf_d;
    if (exp_sum > SUM_HI) result.dec_exponent = SCALE_HI;
    else if (exp_sum < SUM_LO) result.dec_exponent = SCALE_LO;
    else result.dec_exponent = exp_sum[EXP_OUT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_SPACE;
      neg_q       <= 1'b0;
      mant_q      <= '0;
      cnt_q       <= '0;
      scale_q     <= '0;
      exp_q       <= '0;
      exp_neg_q   <= 1'b0;
      lost_q      <= 1'b0;
      exp_ovf_q   <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire && in_q.is_last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (fire) begin
        if (in_q.is_last) begin
          phase_q   <= PH_SPACE;
          neg_q     <= 1'b0;
          mant_q    <= '0;
          cnt_q     <= '0;
          scale_q   <= '0;
          exp_q     <= '0;
          exp_neg_q <= 1'b0;
          lost_q    <= 1'b0;
          exp_ovf_q <= 1'b0;
        end else begin
          phase_q   <= phase_d;
          neg_q     <= neg_d;
          mant_q    <= mant_d;
          cnt_q     <= cnt_d;
          scale_q   <= scale_d;
          exp_q     <= exp_d;
          exp_neg_q <= exp_neg_d;
          lost_q    <= lost_d;
          exp_ovf_q <= exp_ovf_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
    if (fire && in_q.is_last) out_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal text to number parser testbench
// Streams characters into the parser core through a valid/ready channel and
// checks every emitted number against a cycle-free model of the parse, or against
// the value typed into the table. A short table of hand-picked strings runs first,
// then random numbers and bytes under four idle and stall mixes on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import dtnp_pkg::*;

  localparam int unsigned MANT_DIGITS = 18;
  localparam int unsigned EXP_LIMIT   = 9999;
  localparam int          SCALE_MAX   = SCALE_LIMIT;
  localparam int          RANDOM_CHARS_PER_MIX = 100;

  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_VT = 8'h0b;
  localparam logic [7:0] CH_FF = 8'h0c;

  typedef enum logic [3:0] {
    PH_SPACE, PH_SIGN, PH_INT, PH_DOT, PH_FRAC, PH_E, PH_ESIGN, PH_EXP, PH_DONE
  } parse_phase_e;

  typedef struct {
    in_t  item;
    bit   known;
    out_t number;
  } dir_row_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  parse_phase_e acc_phase;
  bit           acc_negative;
  logic [63:0]  acc_mant;
  int unsigned  acc_ndigits;
  int           acc_scale;
  int unsigned  acc_expval;
  bit           acc_expneg;
  bit           acc_lost;
  bit           acc_expsat;

  out_t       expected_numbers[$];
  logic [7:0] text_buf[$];
  int         error_count     = 0;
  int         numbers_checked = 0;
  int         chars_sent      = 0;

  decimal_text_to_number_parser_core #(
    .MANT_DIGITS(MANT_DIGITS),
    .EXP_LIMIT  (EXP_LIMIT)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
           c == CH_FF || c == CH_CR;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic void clear_parser();
    acc_phase    = PH_SPACE;
    acc_negative = 1'b0;
    acc_mant     = '0;
    acc_ndigits  = 0;
    acc_scale    = 0;
    acc_expval   = 0;
    acc_expneg   = 1'b0;
    acc_lost     = 1'b0;
    acc_expsat   = 1'b0;
  endfunction

  function automatic void bump_scale(int d);
    acc_scale = acc_scale + d;
    if (acc_scale > SCALE_MAX) acc_scale = SCALE_MAX;
    if (acc_scale < -SCALE_MAX) acc_scale = -SCALE_MAX;
  endfunction

  function automatic void take_digit(int unsigned d, bit frac);
    if (acc_mant == 0 && d == 0) begin
      if (frac) bump_scale(-1);
      return;
    end
    if (acc_ndigits < MANT_DIGITS) begin
      acc_mant = acc_mant * 64'd10 + 64'(d);
      acc_ndigits++;
      if (frac) bump_scale(-1);
    end else begin
      acc_lost = 1'b1;
      if (!frac) bump_scale(1);
    end
  endfunction

  function automatic void take_exp_digit(int unsigned d);
    int unsigned v;
    v = acc_expval * 10 + d;
    if (v > EXP_LIMIT) begin
      acc_expval = EXP_LIMIT;
      acc_expsat = 1'b1;
    end else begin
      acc_expval = v;
    end
  endfunction

  function automatic void parse_char(logic [7:0] c);
    while (acc_phase != PH_DONE) begin
      case (acc_phase)
        PH_SPACE: begin
          if (is_blank(c)) return;
          acc_phase = PH_SIGN;
        end
        PH_SIGN: begin
          acc_phase = PH_INT;
          if (c == CH_PLUS || c == CH_MINUS) begin
            acc_negative = (c == CH_MINUS);
            return;
          end
        end
        PH_INT: begin
          if (is_digit(c)) begin
            take_digit(int'(c - CH_ZERO), 1'b0);
            return;
          end
          acc_phase = PH_DOT;
        end
        PH_DOT: begin
          acc_phase = PH_FRAC;
          if (c == CH_DOT) return;
        end
        PH_FRAC: begin
          if (is_digit(c)) begin
            take_digit(int'(c - CH_ZERO), 1'b1);
            return;
          end
          acc_phase = PH_E;
        end
        PH_E: begin
          acc_phase = PH_ESIGN;
          if (c == CH_LO_E || c == CH_UP_E) return;
        end
        PH_ESIGN: begin
          acc_phase = PH_EXP;
          if (c == CH_PLUS || c == CH_MINUS) begin
            acc_expneg = (c == CH_MINUS);
            return;
          end
        end
        PH_EXP: begin
          if (is_digit(c)) begin
            take_exp_digit(int'(c - CH_ZERO));
            return;
          end
          acc_phase = PH_DONE;
        end
        default: acc_phase = PH_DONE;
      endcase
    end
  endfunction

  function automatic out_t close_number();
    out_t num;
    int   e;
    e = acc_scale + (acc_expneg ? -int'(acc_expval) : int'(acc_expval));
    if (e > SCALE_MAX) e = SCALE_MAX;
    if (e < -SCALE_MAX) e = -SCALE_MAX;
    num.negative      = acc_negative;
    num.mantissa      = acc_mant[MANT_W-1:0];
    num.dec_exponent  = e[EXP_OUT_W-1:0];
    num.inexact       = acc_lost;
    num.exp_saturated = acc_expsat;
    clear_parser();
    return num;
  endfunction

  function automatic dir_row_t mk_row(logic [7:0] c, logic last, bit known,
                                      logic neg, logic [MANT_W-1:0] mant,
                                      int e, logic inexact, logic sat);
    dir_row_t r;
    r.item.ch              = c;
    r.item.is_last         = last;
    r.known                = known;
    r.number.negative      = neg;
    r.number.mantissa      = mant;
    r.number.dec_exponent  = e[EXP_OUT_W-1:0];
    r.number.inexact       = inexact;
    r.number.exp_saturated = sat;
    return r;
  endfunction

  task automatic send_char(input logic [7:0] c, input logic last, input bit known,
                           input out_t typed);
    in_t  item;
    out_t num;
    item.ch      = c;
    item.is_last = last;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    parse_char(c);
    if (last) begin
      num = close_number();
      expected_numbers.push_back(known ? typed : num);
    end
    chars_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++) begin
      send_char(text_buf[i], i == text_buf.size() - 1, 1'b0, '0);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_numbers.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(9));
  endfunction

  function automatic int rand_count(int lo_max, int hi_min, int hi_max);
    if ($urandom_range(7) == 0) return $urandom_range(hi_max, hi_min);
    return $urandom_range(lo_max);
  endfunction

  task automatic build_number();
    logic [7:0] blanks[6];
    int         n;
    blanks = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
    text_buf.delete();
    n = $urandom_range(2);
    repeat (n) text_buf.push_back(blanks[$urandom_range(5)]);
    case ($urandom_range(2))
      1: text_buf.push_back(CH_PLUS);
      2: text_buf.push_back(CH_MINUS);
      default: ;
    endcase
    n = rand_count(6, 15, 24);
    repeat (n) text_buf.push_back($urandom_range(3) == 0 ? CH_ZERO : rand_digit());
    if ($urandom_range(1)) text_buf.push_back(CH_DOT);
    n = rand_count(6, 15, 22);
    repeat (n) text_buf.push_back($urandom_range(3) == 0 ? CH_ZERO : rand_digit());
    case ($urandom_range(2))
      1: text_buf.push_back(CH_LO_E);
      2: text_buf.push_back(CH_UP_E);
      default: ;
    endcase
    case ($urandom_range(2))
      1: text_buf.push_back(CH_PLUS);
      2: text_buf.push_back(CH_MINUS);
      default: ;
    endcase
    n = rand_count(3, 5, 6);
    repeat (n) text_buf.push_back(rand_digit());
    if ($urandom_range(4) == 0) text_buf.push_back(8'($urandom_range(255)));
    if (text_buf.size() == 0) text_buf.push_back(8'($urandom_range(255)));
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_numbers.size() == 0) begin
        if (error_count < 10) begin
          $display("Unexpected number: neg=%0b mant=%0d exp=%0d inexact=%0b sat=%0b",
                   out_data.negative, out_data.mantissa, $signed(out_data.dec_exponent),
                   out_data.inexact, out_data.exp_saturated);
        end
        error_count++;
      end else begin
        want = expected_numbers.pop_front();
        if (out_data.negative !== want.negative || out_data.mantissa !== want.mantissa ||
            out_data.dec_exponent !== want.dec_exponent ||
            out_data.inexact !== want.inexact ||
            out_data.exp_saturated !== want.exp_saturated) begin
          if (error_count < 10) begin
            $display("Mismatch on number %0d:", numbers_checked);
            $display("  expected neg=%0b mant=%0d exp=%0d inexact=%0b sat=%0b",
                     want.negative, want.mantissa, $signed(want.dec_exponent),
                     want.inexact, want.exp_saturated);
            $display("  actual   neg=%0b mant=%0d exp=%0d inexact=%0b sat=%0b",
                     out_data.negative, out_data.mantissa, $signed(out_data.dec_exponent),
                     out_data.inexact, out_data.exp_saturated);
          end
          error_count++;
        end
        numbers_checked++;
      end
    end
  end

  initial begin
    dir_row_t dir_rows[$];
    int       send_pct[4];
    int       recv_pct[4];
    int       directed_chars;
    int       random_chars;
    int       kind;
    int       pos;

    send_pct = '{0, 86, 0, 21};
    recv_pct = '{0, 0, 86, 21};
    clear_parser();

    // Lone white space, lone sign, leading zeros in the fraction with an exponent,
    // a second point that stops the parse, an exponent beyond its limit, an
    // exponent sign with no 'e', and a byte that fits no part at all.
    dir_rows.push_back(mk_row(CH_TAB, 1'b1, 1'b1, 1'b0, '0, 0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(CH_MINUS, 1'b1, 1'b1, 1'b1, '0, 0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(CH_ZERO, 1'b0, 1'b0, 1'b0, '0, 0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(CH_DOT, 1'b0, 1'b0, 1'b0, '0, 0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(CH_ZERO, 1'b0, 1'b0, 1'b0, '0, 0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(CH_ZERO + 8'd5, 1'b0, 1'b0, 1'b0, '0, 0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(CH_UP_E, 1'b0, 1'b0, 1'b0, '0, 0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(CH_MINUS, 1'b0, 1'b0, 1'b0, '0, 0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(CH_ZERO + 8'd3, 1'b1, 1'b0, 1'b0, '0, 0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(CH_ZERO + 8'd1, 1'b0, 1'b0, 1'b0, '0, 0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(CH_DOT, 1'b0, 1'b0, 1'b0, '0, 0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(CH_ZERO + 8'd2, 1'b0, 1'b0, 1'b0, '0, 0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(CH_DOT, 1'b0, 1'b0, 1'b0, '0, 0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(CH_ZERO + 8'd3, 1'b1, 1'b0, 1'b0, '0, 0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(CH_LO_E, 1'b0, 1'b0, 1'b0, '0, 0, 1'b0, 1'b0));
    repeat (4) dir_rows.push_back(mk_row(CH_NINE, 1'b0, 1'b0, 1'b0, '0, 0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(CH_NINE, 1'b1, 1'b1, 1'b0, '0, 9999, 1'b0, 1'b1));
    dir_rows.push_back(mk_row(CH_ZERO + 8'd1, 1'b0, 1'b0, 1'b0, '0, 0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(CH_ZERO + 8'd2, 1'b0, 1'b0, 1'b0, '0, 0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(CH_PLUS, 1'b0, 1'b0, 1'b0, '0, 0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(CH_ZERO + 8'd3, 1'b1, 1'b0, 1'b0, '0, 0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(8'hff, 1'b1, 1'b1, 1'b0, '0, 0, 1'b0, 1'b0));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      send_char(dir_rows[i].item.ch, dir_rows[i].item.is_last, dir_rows[i].known,
                dir_rows[i].number);
    end
    directed_chars = chars_sent;
    wait_drained();

    for (int mix = 0; mix < 4; mix++) begin
      send_idle_pct  = send_pct[mix];
      recv_stall_pct = recv_pct[mix];
      while (chars_sent - directed_chars < RANDOM_CHARS_PER_MIX * (mix + 1)) begin
        kind = $urandom_range(19);
        if (kind < 3) begin
          text_buf.delete();
          repeat ($urandom_range(6, 1)) text_buf.push_back(8'($urandom_range(255)));
        end else begin
          build_number();
          if (kind < 6) begin
            pos = $urandom_range(text_buf.size() - 1);
            text_buf[pos] = 8'($urandom_range(255));
          end
        end
        send_text();
      end
      wait_drained();
    end
    random_chars = chars_sent - directed_chars;

    repeat (10) @(posedge clk);
    $display("Streamed %0d characters (%0d table, %0d random) and checked %0d numbers.",
             chars_sent, directed_chars, random_chars, numbers_checked);
    $display("Idle mixes run: none, sender 86%%, receiver 86%%, both 21%%.");
    if (error_count == 0 && expected_numbers.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
